>>> sv/normalized_difference_stats_defines.svh
// Assertion macros for the normalized difference statistics block.
// Each assumes clk and rst_n are visible where it is used.
`ifndef NORMALIZED_DIFFERENCE_STATS_DEFINES_SVH
`define NORMALIZED_DIFFERENCE_STATS_DEFINES_SVH

`ifndef ASSERT_OFF
`define NDS_ASSERT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define NDS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define NDS_ASSERT(label, ante, cons, msg)
`define NDS_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

>>> sv/ndstat_pkg.sv
`timescale 1ns / 1ps

package ndstat_pkg;

    localparam int SAMPLE_BITS_DEF       = 16;
    localparam int FRAME_PIXELS_LOG2_DEF = 22;
    localparam int FRACTION_BITS_DEF     = 14;

    localparam int ADDR_W = 3;
    localparam logic [ADDR_W-1:0] REG_SUM_THRESHOLD = 3'd0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_ND_DIV,
        ST_ACC,
        ST_MEAN,
        ST_ABS_DIV,
        ST_RAT_DIV,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic add;
        logic clear;
    } acc_ctl_t;

    // dividend width: widest of the two frame totals
    function automatic int dvd_width(int s, int l, int f);
        int abs_w;
        int rat_w;
        abs_w = s + l;
        rat_w = f + 2 + l;
        return (abs_w > rat_w) ? abs_w : rat_w;
    endfunction

    // divisor width: band sum or valid count
    function automatic int dvs_width(int s, int l);
        return ((s + 1) > (l + 1)) ? (s + 1) : (l + 1);
    endfunction

endpackage

>>> sv/ndstat_if.sv
`timescale 1ns / 1ps

interface ndstat_pix_if #(
    parameter int SAMPLE_BITS = ndstat_pkg::SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] sample_a;
    logic [SAMPLE_BITS-1:0] sample_b;
    logic                   frame_last;

    modport source (output valid, sample_a, sample_b, frame_last, input ready);
    modport sink   (input valid, sample_a, sample_b, frame_last, output ready);
endinterface

interface ndstat_res_if #(
    parameter int SAMPLE_BITS   = ndstat_pkg::SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = ndstat_pkg::FRACTION_BITS_DEF
);
    logic                            valid;
    logic                            ready;
    logic signed [FRACTION_BITS+1:0] nd_value;
    logic                            pixel_valid;
    logic                            frame_done;
    logic [SAMPLE_BITS-1:0]          mean_abs_diff;
    logic signed [FRACTION_BITS+1:0] mean_ratio;

    modport source (output valid, nd_value, pixel_valid, frame_done, mean_abs_diff,
                    mean_ratio, input ready);
    modport sink   (input valid, nd_value, pixel_valid, frame_done, mean_abs_diff,
                    mean_ratio, output ready);
endinterface

>>> sv/normalized_difference_stats.sv
`timescale 1ns / 1ps
// Channel  Dir  Handshake        Word
// pix      in   valid / ready    sample_a, sample_b, frame_last
// res      out  valid / ready    nd_value, pixel_valid, frame_done, mean_abs_diff, mean_ratio
// apb      in   psel / penable   sum_threshold at address 0
//
// Pixel with band sum above threshold: its nd value comes from the bit-serial
// restoring divider, one quotient bit per cycle.
// Pixel at or below threshold: no division, nd value zero.
// Last pixel of a frame adds the two mean divisions through the same divider,
// skipped when no pixel was valid.
// A finished word waits in the output register; pix is taken again meanwhile.
// rst_n clears threshold, frame totals, state and output valid.

module normalized_difference_stats #(
    parameter int SAMPLE_BITS       = ndstat_pkg::SAMPLE_BITS_DEF,
    parameter int FRAME_PIXELS_LOG2 = ndstat_pkg::FRAME_PIXELS_LOG2_DEF,
    parameter int FRACTION_BITS     = ndstat_pkg::FRACTION_BITS_DEF,
    localparam int DATA_W = ((SAMPLE_BITS + 1) > 32) ? 64 : 32
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ndstat_pkg::ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0]             pwdata,
    output logic [DATA_W-1:0]             prdata,
    output logic                          pready,
    ndstat_pix_if.sink                    pix,
    ndstat_res_if.source                  res
);
    import ndstat_pkg::*;

    localparam int S        = SAMPLE_BITS;
    localparam int F        = FRACTION_BITS;
    localparam int THR_W    = S + 1;
    localparam int ABS_W    = S + FRAME_PIXELS_LOG2;
    localparam int RAT_W    = F + 2 + FRAME_PIXELS_LOG2;
    localparam int CNT_W    = FRAME_PIXELS_LOG2 + 1;
    localparam int ND_W     = F + 2;
    localparam int DVD_W    = dvd_width(S, FRAME_PIXELS_LOG2, F);
    localparam int DVS_W    = dvs_width(S, FRAME_PIXELS_LOG2);
    localparam int REM_W    = DVS_W + 1;
    localparam int IT_W     = $clog2(DVD_W + 1);
    localparam int ADDR_LSB = (DATA_W == 64) ? 3 : 2;

    localparam logic [IT_W-1:0]  ND_ITERS   = IT_W'(F + 1);
    localparam logic [IT_W-1:0]  MEAN_ITERS = IT_W'(DVD_W);
    localparam logic [DVD_W-1:0] ONE_Q      = DVD_W'(1) << F;

    // config register
    logic [THR_W-1:0] thr_reg;
    logic             addr_hit;

    assign addr_hit = (paddr >> ADDR_LSB) == REG_SUM_THRESHOLD;
    assign pready   = 1'b1;
    assign prdata   = addr_hit ? DATA_W'(thr_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg <= '0;
        end
        else if (psel && penable && pwrite && addr_hit)
        begin
            thr_reg <= pwdata[THR_W-1:0];
        end
    end

    // datapath state
    state_t state_reg, state_next;

    logic [S-1:0]           a_reg, a_next;
    logic [S-1:0]           b_reg, b_next;
    logic                   last_reg, last_next;
    logic [S-1:0]           diff_reg, diff_next;
    logic                   neg_reg, neg_next;
    logic                   valid_reg, valid_next;
    logic signed [ND_W-1:0] nd_reg, nd_next;
    logic [S-1:0]           mabs_reg, mabs_next;
    logic signed [ND_W-1:0] mrat_reg, mrat_next;

    logic                   res_valid_reg, res_valid_next;
    logic signed [ND_W-1:0] res_nd_reg, res_nd_next;
    logic                   res_pv_reg, res_pv_next;
    logic                   res_fd_reg, res_fd_next;
    logic [S-1:0]           res_mabs_reg, res_mabs_next;
    logic signed [ND_W-1:0] res_mrat_reg, res_mrat_next;

    // pixel arithmetic
    logic [THR_W-1:0] sum_c;
    logic [S-1:0]     diff_c;
    logic             neg_c;
    logic             valid_c;

    assign sum_c   = {1'b0, a_reg} + {1'b0, b_reg};
    assign neg_c   = a_reg < b_reg;
    assign diff_c  = neg_c ? (b_reg - a_reg) : (a_reg - b_reg);
    assign valid_c = sum_c > thr_reg;

    // divider
    logic             div_start;
    logic [IT_W-1:0]  div_iters;
    logic [REM_W-1:0] div_rem;
    logic [DVD_W-1:0] div_dvd;
    logic [DVS_W-1:0] div_dvs;
    logic             div_busy;
    logic             div_done;
    logic [DVD_W-1:0] div_quo;

    ndstat_div #(
        .SAMPLE_BITS       (SAMPLE_BITS),
        .FRAME_PIXELS_LOG2 (FRAME_PIXELS_LOG2),
        .FRACTION_BITS     (FRACTION_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .iters    (div_iters),
        .rem_init (div_rem),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    // frame totals
    acc_ctl_t         acc_ctl;
    logic [ABS_W-1:0] abs_total;
    logic [RAT_W-1:0] ratio_total;
    logic [CNT_W-1:0] valid_total;

    ndstat_acc #(
        .SAMPLE_BITS       (SAMPLE_BITS),
        .FRAME_PIXELS_LOG2 (FRAME_PIXELS_LOG2),
        .FRACTION_BITS     (FRACTION_BITS)
    ) u_acc (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (acc_ctl),
        .diff        (diff_reg),
        .nd          (nd_reg),
        .abs_total   (abs_total),
        .ratio_total (ratio_total),
        .valid_total (valid_total)
    );

    logic             rat_neg;
    logic [RAT_W-1:0] rat_mag;
    logic [F:0]       q_nd;
    logic [S-1:0]     q_abs_sat;
    logic [F:0]       q_rat_sat;
    logic             res_free;

    assign rat_neg   = ratio_total[RAT_W-1];
    assign rat_mag   = rat_neg ? (~ratio_total + RAT_W'(1)) : ratio_total;
    assign q_nd      = div_quo[F:0];
    assign q_abs_sat = (div_quo[DVD_W-1:S] != '0) ? {S{1'b1}} : div_quo[S-1:0];
    assign q_rat_sat = (div_quo > ONE_Q) ? ONE_Q[F:0] : div_quo[F:0];
    assign res_free  = !res_valid_reg || res.ready;

    always_comb
    begin
        state_next     = state_reg;
        a_next         = a_reg;
        b_next         = b_reg;
        last_next      = last_reg;
        diff_next      = diff_reg;
        neg_next       = neg_reg;
        valid_next     = valid_reg;
        nd_next        = nd_reg;
        mabs_next      = mabs_reg;
        mrat_next      = mrat_reg;
        res_valid_next = res_valid_reg;
        res_nd_next    = res_nd_reg;
        res_pv_next    = res_pv_reg;
        res_fd_next    = res_fd_reg;
        res_mabs_next  = res_mabs_reg;
        res_mrat_next  = res_mrat_reg;
        div_start      = 1'b0;
        div_iters      = MEAN_ITERS;
        div_rem        = '0;
        div_dvd        = DVD_W'(abs_total);
        div_dvs        = DVS_W'(valid_total);
        acc_ctl        = '0;
        pix.ready      = 1'b0;

        if (res_valid_reg && res.ready)
        begin
            res_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                pix.ready = 1'b1;
                if (pix.valid)
                begin
                    a_next     = pix.sample_a;
                    b_next     = pix.sample_b;
                    last_next  = pix.frame_last;
                    state_next = ST_SETUP;
                end
            end
            ST_SETUP:
            begin
                diff_next  = diff_c;
                neg_next   = neg_c;
                valid_next = valid_c;
                if (valid_c)
                begin
                    // prefix diff>>1 is below the sum, so start there
                    div_start  = 1'b1;
                    div_iters  = ND_ITERS;
                    div_rem    = REM_W'(diff_c[S-1:1]);
                    div_dvd    = {diff_c[0], {(DVD_W-1){1'b0}}};
                    div_dvs    = DVS_W'(sum_c);
                    state_next = ST_ND_DIV;
                end
                else
                begin
                    nd_next    = '0;
                    state_next = ST_ACC;
                end
            end
            ST_ND_DIV:
            begin
                if (div_done)
                begin
                    nd_next    = neg_reg ? -$signed({1'b0, q_nd}) : $signed({1'b0, q_nd});
                    state_next = ST_ACC;
                end
            end
            ST_ACC:
            begin
                acc_ctl.add = valid_reg;
                state_next  = last_reg ? ST_MEAN : ST_FINISH;
            end
            ST_MEAN:
            begin
                if (valid_total == '0)
                begin
                    mabs_next  = '0;
                    mrat_next  = '0;
                    state_next = ST_FINISH;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = ST_ABS_DIV;
                end
            end
            ST_ABS_DIV:
            begin
                if (div_done)
                begin
                    mabs_next  = q_abs_sat;
                    div_start  = 1'b1;
                    div_dvd    = DVD_W'(rat_mag);
                    state_next = ST_RAT_DIV;
                end
            end
            ST_RAT_DIV:
            begin
                if (div_done)
                begin
                    mrat_next  = rat_neg ? -$signed({1'b0, q_rat_sat})
                                         : $signed({1'b0, q_rat_sat});
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (res_free)
                begin
                    res_valid_next = 1'b1;
                    res_nd_next    = nd_reg;
                    res_pv_next    = valid_reg;
                    res_fd_next    = last_reg;
                    res_mabs_next  = last_reg ? mabs_reg : '0;
                    res_mrat_next  = last_reg ? mrat_reg : '0;
                    acc_ctl.clear  = last_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg        <= a_next;
        b_reg        <= b_next;
        last_reg     <= last_next;
        diff_reg     <= diff_next;
        neg_reg      <= neg_next;
        valid_reg    <= valid_next;
        nd_reg       <= nd_next;
        mabs_reg     <= mabs_next;
        mrat_reg     <= mrat_next;
        res_nd_reg   <= res_nd_next;
        res_pv_reg   <= res_pv_next;
        res_fd_reg   <= res_fd_next;
        res_mabs_reg <= res_mabs_next;
        res_mrat_reg <= res_mrat_next;
    end

    assign res.valid         = res_valid_reg;
    assign res.nd_value      = res_nd_reg;
    assign res.pixel_valid   = res_pv_reg;
    assign res.frame_done    = res_fd_reg;
    assign res.mean_abs_diff = res_mabs_reg;
    assign res.mean_ratio    = res_mrat_reg;

`include "normalized_difference_stats_defines.svh"

    `NDS_ASSERT(a_div_idle_on_start, div_start, !div_busy, "divider restarted while busy")
    `NDS_ASSERT(a_invalid_nd_zero, res.valid && !res.pixel_valid, res.nd_value == '0, "nd nonzero on invalid pixel")
    `NDS_ASSERT(a_means_only_on_done, res.valid && !res.frame_done, res.mean_abs_diff == '0 && res.mean_ratio == '0, "means nonzero off frame end")
    `NDS_ASSERT_NEXT(a_accept_to_setup, pix.valid && pix.ready, state_reg == ST_SETUP, "accepted word not processed")

endmodule

>>> sv/ndstat_div.sv
`timescale 1ns / 1ps

module ndstat_div #(
    parameter int SAMPLE_BITS       = ndstat_pkg::SAMPLE_BITS_DEF,
    parameter int FRAME_PIXELS_LOG2 = ndstat_pkg::FRAME_PIXELS_LOG2_DEF,
    parameter int FRACTION_BITS     = ndstat_pkg::FRACTION_BITS_DEF,
    localparam int DVD_W = ndstat_pkg::dvd_width(SAMPLE_BITS, FRAME_PIXELS_LOG2,
                                                 FRACTION_BITS),
    localparam int DVS_W = ndstat_pkg::dvs_width(SAMPLE_BITS, FRAME_PIXELS_LOG2),
    localparam int REM_W = DVS_W + 1,
    localparam int IT_W  = $clog2(DVD_W + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [IT_W-1:0]  iters,
    input  logic [REM_W-1:0] rem_init,
    input  logic [DVD_W-1:0] dividend,
    input  logic [DVS_W-1:0] divisor,
    output logic             busy,
    output logic             done,
    output logic [DVD_W-1:0] quotient
);
    import ndstat_pkg::*;

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [IT_W-1:0]  cnt_reg, cnt_next;
    logic [REM_W-1:0] rem_reg, rem_next;
    logic [DVD_W-1:0] dvd_reg, dvd_next;
    logic [DVD_W-1:0] quo_reg, quo_next;
    logic [DVS_W-1:0] dvs_reg, dvs_next;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W:0]   trial;
    logic             ge;

    // restoring step: one quotient bit per cycle
    assign rem_sh = {rem_reg[REM_W-2:0], dvd_reg[DVD_W-1]};
    assign trial  = {1'b0, rem_sh} - {2'b00, dvs_reg};
    assign ge     = ~trial[REM_W];

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = iters;
            rem_next  = rem_init;
            dvd_next  = dividend;
            quo_next  = '0;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? trial[REM_W-1:0] : rem_sh;
            dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            quo_next = {quo_reg[DVD_W-2:0], ge};
            cnt_next = cnt_reg - IT_W'(1);
            if (cnt_reg == IT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> sv/ndstat_acc.sv
`timescale 1ns / 1ps

module ndstat_acc #(
    parameter int SAMPLE_BITS       = ndstat_pkg::SAMPLE_BITS_DEF,
    parameter int FRAME_PIXELS_LOG2 = ndstat_pkg::FRAME_PIXELS_LOG2_DEF,
    parameter int FRACTION_BITS     = ndstat_pkg::FRACTION_BITS_DEF,
    localparam int ABS_W = SAMPLE_BITS + FRAME_PIXELS_LOG2,
    localparam int RAT_W = FRACTION_BITS + 2 + FRAME_PIXELS_LOG2,
    localparam int CNT_W = FRAME_PIXELS_LOG2 + 1,
    localparam int ND_W  = FRACTION_BITS + 2
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  ndstat_pkg::acc_ctl_t    ctl,
    input  logic [SAMPLE_BITS-1:0]  diff,
    input  logic signed [ND_W-1:0]  nd,
    output logic [ABS_W-1:0]        abs_total,
    output logic [RAT_W-1:0]        ratio_total,
    output logic [CNT_W-1:0]        valid_total
);
    import ndstat_pkg::*;

    logic [ABS_W-1:0] abs_reg, abs_next;
    logic [RAT_W-1:0] rat_reg, rat_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    always_comb
    begin
        abs_next = abs_reg;
        rat_next = rat_reg;
        cnt_next = cnt_reg;
        priority if (ctl.clear)
        begin
            abs_next = '0;
            rat_next = '0;
            cnt_next = '0;
        end
        else if (ctl.add)
        begin
            abs_next = abs_reg + {{FRAME_PIXELS_LOG2{1'b0}}, diff};
            rat_next = rat_reg + {{FRAME_PIXELS_LOG2{nd[ND_W-1]}}, nd};
            cnt_next = cnt_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            abs_reg <= '0;
            rat_reg <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            abs_reg <= abs_next;
            rat_reg <= rat_next;
            cnt_reg <= cnt_next;
        end
    end

    assign abs_total   = abs_reg;
    assign ratio_total = rat_reg;
    assign valid_total = cnt_reg;

endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

    import ndstat_pkg::*;

    localparam int SW       = SAMPLE_BITS_DEF;
    localparam int FW       = FRACTION_BITS_DEF;
    localparam int ABS_W    = SAMPLE_BITS_DEF + FRAME_PIXELS_LOG2_DEF;
    localparam int RAT_W    = FRACTION_BITS_DEF + 2 + FRAME_PIXELS_LOG2_DEF;
    localparam int CNT_W    = FRAME_PIXELS_LOG2_DEF + 1;
    localparam int THR_W    = SAMPLE_BITS_DEF + 1;
    localparam int THR_MAX  = (1 << THR_W) - 2;
    localparam int ND_ONE   = 1 << FRACTION_BITS_DEF;
    localparam int SETTLE   = 120;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_OFF = 300;

    typedef struct packed {
        logic signed [FW+1:0] nd_value;
        logic                 pixel_valid;
        logic                 frame_done;
        logic [SW-1:0]        mean_abs_diff;
        logic signed [FW+1:0] mean_ratio;
    } pixel_result_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ndstat_pix_if pix_ch ();
    ndstat_res_if res_ch ();

    normalized_difference_stats i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .pix     (pix_ch),
        .res     (res_ch)
    );

    // frame totals and threshold as the block should hold them
    logic [THR_W-1:0] threshold_reg;
    logic [ABS_W-1:0] abs_diff_sum;
    logic [RAT_W-1:0] nd_sum;
    logic [CNT_W-1:0] valid_pixels;

    pixel_result_t pending_results[$];
    int  mismatch_count;
    int  stall_cycles;
    int  hold_cycles;
    bit  idle_on;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic pixel_result_t predict_pixel(logic [SW-1:0] a, logic [SW-1:0] b,
                                                    logic last);
        pixel_result_t r;
        logic [SW:0]        band_sum;
        logic [SW-1:0]      diff;
        logic [SW+FW:0]     quo;
        logic [RAT_W-1:0]   mag;
        logic [RAT_W-1:0]   ratio_q;
        logic [ABS_W-1:0]   abs_q;
        logic               neg;
        r = '0;
        band_sum = {1'b0, a} + {1'b0, b};
        r.pixel_valid = band_sum > threshold_reg;
        if (r.pixel_valid)
        begin
            diff = (a >= b) ? a - b : b - a;
            quo = {diff, {FW{1'b0}}} / band_sum;
            r.nd_value = (a >= b) ? quo[FW+1:0] : -quo[FW+1:0];
            abs_diff_sum = abs_diff_sum + diff;
            nd_sum = nd_sum + {{(RAT_W-FW-2){r.nd_value[FW+1]}}, r.nd_value};
            valid_pixels = valid_pixels + 1'b1;
        end
        if (last)
        begin
            r.frame_done = 1'b1;
            if (valid_pixels != 0)
            begin
                neg = nd_sum[RAT_W-1];
                mag = neg ? -nd_sum : nd_sum;
                ratio_q = mag / valid_pixels;
                abs_q = abs_diff_sum / valid_pixels;
                r.mean_abs_diff = (abs_q > {SW{1'b1}}) ? {SW{1'b1}} : abs_q[SW-1:0];
                if (ratio_q > ND_ONE)
                    ratio_q = RAT_W'(ND_ONE);
                r.mean_ratio = neg ? -ratio_q[FW+1:0] : ratio_q[FW+1:0];
            end
            abs_diff_sum = '0;
            nd_sum = '0;
            valid_pixels = '0;
        end
        return r;
    endfunction

    function automatic void check_field(string name, longint want, longint got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // result checker
    always @(posedge clk)
    begin : check_result
        pixel_result_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result word with no pixel pending");
                mismatch_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("nd_value", want.nd_value, res_ch.nd_value);
                check_field("pixel_valid", want.pixel_valid, res_ch.pixel_valid);
                check_field("frame_done", want.frame_done, res_ch.frame_done);
                check_field("mean_abs_diff", want.mean_abs_diff, res_ch.mean_abs_diff);
                check_field("mean_ratio", want.mean_ratio, res_ch.mean_ratio);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || psel || (pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready))
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("normalized_difference_stats test failed");
            $finish;
        end
    end

    // result receiver: random stalls plus an occasional long hold-off
    initial
    begin : result_receiver
        int gap;
        res_ch.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                res_ch.ready = 1'b0;
                repeat (hold_cycles) @(negedge clk);
                hold_cycles = 0;
            end
            gap = idle_on ? $urandom_range(0, 5) : 0;
            if (gap > 0)
            begin
                res_ch.ready = 1'b0;
                repeat (gap) @(negedge clk);
            end
            res_ch.ready = 1'b1;
            do @(posedge clk); while (!res_ch.valid);
        end
    end

    task automatic send_pixel(logic [SW-1:0] a, logic [SW-1:0] b, logic last);
        int gap;
        gap = idle_on ? $urandom_range(0, 5) : 0;
        @(negedge clk);
        if (gap > 0)
        begin
            pix_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        pix_ch.valid      = 1'b1;
        pix_ch.sample_a   = a;
        pix_ch.sample_b   = b;
        pix_ch.frame_last = last;
        do @(posedge clk); while (!pix_ch.ready);
        pending_results.push_back(predict_pixel(a, b, last));
    endtask

    task automatic pixels_off();
        @(negedge clk);
        pix_ch.valid = 1'b0;
    endtask

    task automatic wait_drained();
        pixels_off();
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_reg(logic [ADDR_W-1:0] addr, logic [31:0] data);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic read_reg(logic [ADDR_W-1:0] addr, output logic [31:0] data);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = addr;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        data = prdata;
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_threshold(int unsigned value);
        logic [31:0] rd;
        wait_drained();
        write_reg(REG_SUM_THRESHOLD, value);
        threshold_reg = value[THR_W-1:0];
        read_reg(REG_SUM_THRESHOLD, rd);
        check_field("sum_threshold", threshold_reg, rd);
    endtask

    function automatic void pick_pair(output logic [SW-1:0] a, output logic [SW-1:0] b);
        int unsigned target;
        case ($urandom_range(0, 5))
            0, 1:
            begin
                a = SW'($urandom);
                b = SW'($urandom);
            end
            2:
            begin
                a = SW'($urandom_range(0, 15));
                b = SW'($urandom_range(0, 15));
            end
            3:
            begin
                a = SW'($urandom_range(65520, 65535));
                b = SW'($urandom_range(0, 255));
            end
            4:
            begin
                a = SW'($urandom_range(0, 255));
                b = SW'($urandom);
            end
            default:
            begin
                // land on either side of the threshold
                target = threshold_reg + $urandom_range(0, 2);
                if (target > 0)
                    target = target - 1;
                if (target > THR_MAX)
                    target = THR_MAX;
                if (target > 65535)
                    a = SW'($urandom_range(target - 65535, 65535));
                else
                    a = SW'($urandom_range(0, target));
                b = SW'(target - a);
            end
        endcase
    endfunction

    task automatic run_frames(int count);
        logic [SW-1:0] a;
        logic [SW-1:0] b;
        int frame_left;
        frame_left = $urandom_range(1, 40);
        for (int i = 0; i < count; i++)
        begin
            pick_pair(a, b);
            frame_left--;
            send_pixel(a, b, frame_left == 0);
            if (frame_left == 0)
                frame_left = ($urandom_range(0, 5) == 0) ? 1 : $urandom_range(2, 40);
        end
    endtask

    task automatic test_register_reset();
        logic [31:0] rd;
        read_reg(REG_SUM_THRESHOLD, rd);
        check_field("sum_threshold", 0, rd);
    endtask

    task automatic test_directed();
        // zero sum, full scale both signs, equal bands, tiny values
        send_pixel(16'd0, 16'd0, 1'b0);
        send_pixel(16'hffff, 16'd0, 1'b0);
        send_pixel(16'd0, 16'hffff, 1'b0);
        send_pixel(16'hffff, 16'hffff, 1'b0);
        send_pixel(16'd1, 16'd0, 1'b0);
        send_pixel(16'd0, 16'd1, 1'b0);
        send_pixel(16'd1, 16'd2, 1'b0);
        send_pixel(16'd40000, 16'd12345, 1'b1);
        // frame with no valid pixels
        send_pixel(16'd0, 16'd0, 1'b1);
        // negative mean
        send_pixel(16'd0, 16'hffff, 1'b0);
        send_pixel(16'd0, 16'hffff, 1'b0);
        send_pixel(16'd1, 16'hffff, 1'b1);
        set_threshold(THR_MAX);
        send_pixel(16'hffff, 16'hffff, 1'b0);
        send_pixel(16'hffff, 16'hfffe, 1'b1);
        set_threshold(THR_MAX - 1);
        send_pixel(16'hffff, 16'hffff, 1'b0);
        send_pixel(16'hffff, 16'hfffe, 1'b1);
        set_threshold(1000);
        send_pixel(16'd500, 16'd500, 1'b0);
        send_pixel(16'd500, 16'd501, 1'b0);
        send_pixel(16'd1000, 16'd1, 1'b1);
    endtask

    task automatic test_random_thresholds();
        set_threshold(0);
        run_frames(200);
        set_threshold($urandom_range(0, THR_MAX));
        run_frames(150);
        set_threshold(THR_MAX);
        run_frames(40);
        set_threshold(THR_MAX - 1);
        run_frames(60);
        set_threshold(65535);
        run_frames(150);
        set_threshold($urandom_range(0, 2000));
        run_frames(150);
    endtask

    task automatic test_output_hold_off();
        set_threshold($urandom_range(0, 300));
        hold_cycles = HOLD_OFF;
        idle_on = 1'b0;
        run_frames(40);
        idle_on = 1'b1;
    endtask

    task automatic test_back_to_back();
        set_threshold(0);
        idle_on = 1'b0;
        run_frames(100);
        idle_on = 1'b1;
    endtask

    initial
    begin
        clk               = 1'b0;
        rst_n             = 1'b0;
        psel              = 1'b0;
        penable           = 1'b0;
        pwrite            = 1'b0;
        paddr             = '0;
        pwdata            = '0;
        pix_ch.valid      = 1'b0;
        pix_ch.sample_a   = '0;
        pix_ch.sample_b   = '0;
        pix_ch.frame_last = 1'b0;
        threshold_reg     = '0;
        abs_diff_sum      = '0;
        nd_sum            = '0;
        valid_pixels      = '0;
        mismatch_count    = 0;
        stall_cycles      = 0;
        hold_cycles       = 0;
        idle_on           = 1'b1;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_register_reset();
        test_directed();
        test_random_thresholds();
        test_output_hold_off();
        test_back_to_back();

        wait_drained();
        if (mismatch_count == 0)
            $display("normalized_difference_stats test passed");
        else
            $display("normalized_difference_stats test failed");
        $finish;
    end

endmodule
